[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked assertions on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define TGC_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("touch grid map: assertion failed");

// Next-cycle implication.
`define TGC_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("touch grid map: assertion failed");

`endif

[sv/tgc_pkg.sv]
// ----------------------------------------------------------------------------
// tgc_pkg
// Shared constants, register codes and helper functions of the touch grid map.
// ----------------------------------------------------------------------------
`default_nettype none

package tgc_pkg;

  localparam int RAW_BITS_DEF    = 14;
  localparam int OFFSET_BITS_DEF = 7;
  localparam int FRAC_BITS_DEF   = 16;

  localparam int OUT_W     = 17;
  localparam int SCREEN_W  = 32;
  localparam int DIM_W     = 16;
  localparam int ORIENT_W  = 7;
  localparam int CFG_IDX_W = 3;
  localparam int GRID_PTS  = 9;

  localparam logic [SCREEN_W-1:0] SCREEN_RST = 32'd39322400;

  localparam int SAT_MAX = 65535;
  localparam int SAT_MIN = -65536;

  // orient_mode bit positions
  localparam int OR_BYPASS = 0;
  localparam int OR_SWAP_X = 1;
  localparam int OR_SWAP_Y = 2;
  localparam int OR_PANEL  = 3;
  localparam int OR_DISP   = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_X_MIN,
    CFG_X_MAX,
    CFG_Y_MIN,
    CFG_Y_MAX,
    CFG_SCREEN,
    CFG_ORIENT,
    CFG_GRID_DX,
    CFG_GRID_DY
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PANEL_NONE,
    PANEL_CW,
    PANEL_CCW,
    PANEL_RSVD
  } panel_e;

  typedef enum logic [1:0] {
    DISP_0,
    DISP_90,
    DISP_180,
    DISP_270
  } disp_e;

  typedef struct packed {
    logic fault;
    logic col;
    logic row;
    logic xneg;
    logic yneg;
  } tgc_flags_t;

  function automatic logic panel_turned(input logic [ORIENT_W-1:0] orient);
    panel_e p;
    p = panel_e'(orient[OR_PANEL +: 2]);
    return (p == PANEL_CW) || (p == PANEL_CCW);
  endfunction

  // Effective width after a panel rotation.
  function automatic logic [DIM_W-1:0] eff_w(input logic [SCREEN_W-1:0] screen,
                                             input logic [ORIENT_W-1:0] orient);
    return panel_turned(orient) ? screen[DIM_W +: DIM_W] : screen[DIM_W-1:0];
  endfunction

  // Effective height after a panel rotation.
  function automatic logic [DIM_W-1:0] eff_h(input logic [SCREEN_W-1:0] screen,
                                             input logic [ORIENT_W-1:0] orient);
    return panel_turned(orient) ? screen[DIM_W-1:0] : screen[DIM_W +: DIM_W];
  endfunction

endpackage

`default_nettype wire

[sv/tgc_in_if.sv]
// ----------------------------------------------------------------------------
// tgc_in_if
// Raw sample channel: valid/ready handshake with one x and one y reading.
// ----------------------------------------------------------------------------
`default_nettype none

interface tgc_in_if #(
  parameter int RAW_BITS = tgc_pkg::RAW_BITS_DEF
) ();
  logic                valid;
  logic                ready;
  logic [RAW_BITS-1:0] raw_x;
  logic [RAW_BITS-1:0] raw_y;

  modport source (output valid, output raw_x, output raw_y, input ready);
  modport sink   (input valid, input raw_x, input raw_y, output ready);
endinterface

`default_nettype wire

[sv/tgc_out_if.sv]
// ----------------------------------------------------------------------------
// tgc_out_if
// Screen position channel: valid/ready handshake with x, y and a fault flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface tgc_out_if ();
  logic                              valid;
  logic                              ready;
  logic signed [tgc_pkg::OUT_W-1:0]  screen_x;
  logic signed [tgc_pkg::OUT_W-1:0]  screen_y;
  logic                              range_fault;

  modport source (output valid, output screen_x, output screen_y, output range_fault,
                  input ready);
  modport sink   (input valid, input screen_x, input screen_y, input range_fault,
                  output ready);
endinterface

`default_nettype wire

[sv/tgc_front.sv]
// ----------------------------------------------------------------------------
// tgc_front
// Three stages: offset from the raw minimum, quadrant pick and distance,
// then distance clamp and the divider operands for linear and fraction terms.
// ----------------------------------------------------------------------------
`default_nettype none

module tgc_front #(
  parameter int RAW_BITS  = tgc_pkg::RAW_BITS_DEF,
  parameter int FRAC_BITS = tgc_pkg::FRAC_BITS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            ce_i,
  input  wire logic [RAW_BITS-1:0]             raw_x_i,
  input  wire logic [RAW_BITS-1:0]             raw_y_i,
  input  wire logic [RAW_BITS-1:0]             x_min_i,
  input  wire logic [RAW_BITS-1:0]             x_max_i,
  input  wire logic [RAW_BITS-1:0]             y_min_i,
  input  wire logic [RAW_BITS-1:0]             y_max_i,
  input  wire logic [tgc_pkg::SCREEN_W-1:0]    screen_i,
  input  wire logic [tgc_pkg::ORIENT_W-1:0]    orient_i,
  output tgc_pkg::tgc_flags_t                  flags_o,
  output logic [RAW_BITS-1:0]                  rx_o,
  output logic [RAW_BITS-1:0]                  ry_o,
  output logic [RAW_BITS+tgc_pkg::DIM_W+FRAC_BITS-1:0] lin_x_num_o,
  output logic [RAW_BITS+tgc_pkg::DIM_W+FRAC_BITS-1:0] lin_y_num_o,
  output logic [RAW_BITS+tgc_pkg::DIM_W+FRAC_BITS-1:0] frc_x_num_o,
  output logic [RAW_BITS+tgc_pkg::DIM_W+FRAC_BITS-1:0] frc_y_num_o,
  output logic [RAW_BITS-1:0]                  mx_o,
  output logic [RAW_BITS-1:0]                  my_o,
  output logic [RAW_BITS-1:0]                  hx_o,
  output logic [RAW_BITS-1:0]                  hy_o
);
  import tgc_pkg::*;

  localparam int XW = RAW_BITS + 1;
  localparam int NXW = XW + 1;
  localparam int NW = RAW_BITS + DIM_W + FRAC_BITS;
  localparam int PRODW = RAW_BITS + DIM_W;

  // stage 1
  logic signed [XW-1:0] xc_q, yc_q, mx_q, my_q;
  logic [RAW_BITS-1:0]  rx1_q, ry1_q;

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      xc_q  <= $signed({1'b0, raw_x_i}) - $signed({1'b0, x_min_i});
      yc_q  <= $signed({1'b0, raw_y_i}) - $signed({1'b0, y_min_i});
      mx_q  <= $signed({1'b0, x_max_i}) - $signed({1'b0, x_min_i});
      my_q  <= $signed({1'b0, y_max_i}) - $signed({1'b0, y_min_i});
      rx1_q <= raw_x_i;
      ry1_q <= raw_y_i;
    end
  end

  // stage 2
  logic [RAW_BITS-1:0]   hx_d, hy_d;
  logic signed [XW-1:0]  hx_s, hy_s, xneg_v, yneg_v;
  logic signed [NXW-1:0] nx_d, ny_d;
  tgc_flags_t            fl2_d;

  always_comb begin
    hx_d = mx_q[RAW_BITS:1];
    hy_d = my_q[RAW_BITS:1];
    hx_s = $signed({1'b0, hx_d});
    hy_s = $signed({1'b0, hy_d});
    fl2_d.fault = (mx_q < $signed(XW'(2))) || (my_q < $signed(XW'(2)));
    fl2_d.col   = (xc_q >= hx_s);
    fl2_d.row   = !(yc_q > hy_s);
    fl2_d.xneg  = xc_q[XW-1];
    fl2_d.yneg  = yc_q[XW-1];
    nx_d = fl2_d.col ? (NXW'(xc_q) - NXW'(hx_s)) : NXW'(xc_q);
    ny_d = fl2_d.row ? NXW'(yc_q) : (NXW'(yc_q) - NXW'(hy_s));
    xneg_v = -xc_q;
    yneg_v = -yc_q;
  end

  logic signed [NXW-1:0] nx_q, ny_q;
  logic [RAW_BITS-1:0]   hx_q, hy_q, mx2_q, my2_q, xmag_q, ymag_q, rx2_q, ry2_q;
  tgc_flags_t            fl2_q;

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      nx_q   <= nx_d;
      ny_q   <= ny_d;
      hx_q   <= hx_d;
      hy_q   <= hy_d;
      mx2_q  <= mx_q[RAW_BITS-1:0];
      my2_q  <= my_q[RAW_BITS-1:0];
      xmag_q <= xc_q[XW-1] ? xneg_v[RAW_BITS-1:0] : xc_q[RAW_BITS-1:0];
      ymag_q <= yc_q[XW-1] ? yneg_v[RAW_BITS-1:0] : yc_q[RAW_BITS-1:0];
      fl2_q  <= fl2_d;
      rx2_q  <= rx1_q;
      ry2_q  <= ry1_q;
    end
  end

  // stage 3: clamp distance into 0..half, scale magnitude by the screen size
  logic [RAW_BITS-1:0] nxs_d, nys_d;
  logic [PRODW-1:0]    px_d, py_d;

  always_comb begin
    if (nx_q[NXW-1]) begin
      nxs_d = '0;
    end else if (nx_q > $signed(NXW'(hx_q))) begin
      nxs_d = hx_q;
    end else begin
      nxs_d = nx_q[RAW_BITS-1:0];
    end
    if (ny_q[NXW-1]) begin
      nys_d = '0;
    end else if (ny_q > $signed(NXW'(hy_q))) begin
      nys_d = hy_q;
    end else begin
      nys_d = ny_q[RAW_BITS-1:0];
    end
    px_d = PRODW'(xmag_q) * PRODW'(eff_w(screen_i, orient_i));
    py_d = PRODW'(ymag_q) * PRODW'(eff_h(screen_i, orient_i));
  end

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      lin_x_num_o <= {px_d, {FRAC_BITS{1'b0}}};
      lin_y_num_o <= {py_d, {FRAC_BITS{1'b0}}};
      frc_x_num_o <= NW'({nxs_d, {FRAC_BITS{1'b0}}});
      frc_y_num_o <= NW'({nys_d, {FRAC_BITS{1'b0}}});
      mx_o        <= mx2_q;
      my_o        <= my2_q;
      hx_o        <= hx_q;
      hy_o        <= hy_q;
      flags_o     <= fl2_q;
      rx_o        <= rx2_q;
      ry_o        <= ry2_q;
    end
  end

endmodule

`default_nettype wire

[sv/tgc_div.sv]
// ----------------------------------------------------------------------------
// tgc_div
// Pipelined restoring divider: one quotient bit per stage, NW stages.
// ----------------------------------------------------------------------------
`default_nettype none

module tgc_div #(
  parameter int NW = 46,
  parameter int DW = 14
) (
  input  wire logic          clk_i,
  input  wire logic          ce_i,
  input  wire logic [NW-1:0] dividend_i,
  input  wire logic [DW-1:0] divisor_i,
  output logic      [NW-1:0] quotient_o
);

  // dividend bits shift out at the top while quotient bits fill in below
  logic [NW-1:0] w_q [NW];
  logic [DW-1:0] r_q [NW];
  logic [DW-1:0] d_q [NW];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [NW-1:0] wi;
    logic [DW-1:0] ri, di;
    logic [DW:0]   trial;
    logic          ge;

    if (k == 0) begin : g_first
      assign wi = dividend_i;
      assign ri = '0;
      assign di = divisor_i;
    end else begin : g_next
      assign wi = w_q[k-1];
      assign ri = r_q[k-1];
      assign di = d_q[k-1];
    end

    assign trial = {ri, wi[NW-1]};
    assign ge    = (trial >= {1'b0, di});

    always_ff @(posedge clk_i) begin
      if (ce_i) begin
        w_q[k] <= {wi[NW-2:0], ge};
        r_q[k] <= ge ? DW'(trial - {1'b0, di}) : DW'(trial);
        d_q[k] <= di;
      end
    end
  end

  assign quotient_o = w_q[NW-1];

endmodule

`default_nettype wire

[sv/tgc_back.sv]
// ----------------------------------------------------------------------------
// tgc_back
// Ten stages: bilinear weights, grid offset products and sum, truncation to
// pixels, axis swaps, panel and display rotation, saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module tgc_back #(
  parameter int RAW_BITS    = tgc_pkg::RAW_BITS_DEF,
  parameter int OFFSET_BITS = tgc_pkg::OFFSET_BITS_DEF,
  parameter int FRAC_BITS   = tgc_pkg::FRAC_BITS_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               ce_i,
  input  wire logic [RAW_BITS+tgc_pkg::DIM_W+FRAC_BITS-1:0] lin_x_i,
  input  wire logic [RAW_BITS+tgc_pkg::DIM_W+FRAC_BITS-1:0] lin_y_i,
  input  wire logic [RAW_BITS+tgc_pkg::DIM_W+FRAC_BITS-1:0] frc_x_i,
  input  wire logic [RAW_BITS+tgc_pkg::DIM_W+FRAC_BITS-1:0] frc_y_i,
  input  tgc_pkg::tgc_flags_t                     flags_i,
  input  wire logic [RAW_BITS-1:0]                rx_i,
  input  wire logic [RAW_BITS-1:0]                ry_i,
  input  wire logic [tgc_pkg::SCREEN_W-1:0]       screen_i,
  input  wire logic [tgc_pkg::ORIENT_W-1:0]       orient_i,
  input  wire logic [tgc_pkg::GRID_PTS*OFFSET_BITS-1:0] grid_dx_i,
  input  wire logic [tgc_pkg::GRID_PTS*OFFSET_BITS-1:0] grid_dy_i,
  output logic signed [tgc_pkg::OUT_W-1:0]        screen_x_o,
  output logic signed [tgc_pkg::OUT_W-1:0]        screen_y_o,
  output logic                                    range_fault_o
);
  import tgc_pkg::*;

  localparam int NW   = RAW_BITS + DIM_W + FRAC_BITS;
  localparam int LW   = NW + 1;
  localparam int FW   = FRAC_BITS + 1;
  localparam int WW   = 2 * FW;
  localparam int PRW  = WW + 1 + OFFSET_BITS;
  localparam int DDW  = PRW + 2;
  localparam int DQW  = DDW - FRAC_BITS;
  localparam int SW   = LW + 1;
  localparam int PW   = SW - FRAC_BITS;
  localparam int OW   = PW + 3;
  localparam int SIDE = 9;
  localparam int IW   = 4;

  localparam logic [FW-1:0] ONE_Q = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic signed [OW-1:0] SAT_HI = OW'(SAT_MAX);
  localparam logic signed [OW-1:0] SAT_LO = OW'(SAT_MIN);

  function automatic logic signed [OFFSET_BITS-1:0] grid_pt(
      input logic [GRID_PTS*OFFSET_BITS-1:0] grid, input logic [IW-1:0] idx);
    return $signed(grid[OFFSET_BITS*idx +: OFFSET_BITS]);
  endfunction

  // fault and raw readings ride along to the last stage
  logic                fault_q [SIDE];
  logic [RAW_BITS-1:0] rxs_q [SIDE];
  logic [RAW_BITS-1:0] rys_q [SIDE];

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      for (int k = 0; k < SIDE; k++) begin
        fault_q[k] <= (k == 0) ? flags_i.fault : fault_q[(k == 0) ? 0 : k-1];
        rxs_q[k]   <= (k == 0) ? rx_i : rxs_q[(k == 0) ? 0 : k-1];
        rys_q[k]   <= (k == 0) ? ry_i : rys_q[(k == 0) ? 0 : k-1];
      end
    end
  end

  // stage 1: signed linear term, corner fractions, corner offsets
  logic signed [LW-1:0] lmx, lmy;
  logic [IW-1:0]        base;
  logic signed [LW-1:0] lx1_q, ly1_q;
  logic [FW-1:0]        cx0_q, cx1_q, cy0_q, cy1_q;
  logic signed [OFFSET_BITS-1:0] gx1_q [4];
  logic signed [OFFSET_BITS-1:0] gy1_q [4];

  always_comb begin
    lmx = $signed({1'b0, lin_x_i});
    lmy = $signed({1'b0, lin_y_i});
    unique case ({flags_i.row, flags_i.col})
      2'b00:   base = IW'(0);
      2'b01:   base = IW'(1);
      2'b10:   base = IW'(3);
      default: base = IW'(4);
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      lx1_q    <= flags_i.xneg ? -lmx : lmx;
      ly1_q    <= flags_i.yneg ? -lmy : lmy;
      cx1_q    <= frc_x_i[FW-1:0];
      cx0_q    <= ONE_Q - frc_x_i[FW-1:0];
      cy0_q    <= frc_y_i[FW-1:0];
      cy1_q    <= ONE_Q - frc_y_i[FW-1:0];
      gx1_q[0] <= grid_pt(grid_dx_i, base);
      gx1_q[1] <= grid_pt(grid_dx_i, base + IW'(1));
      gx1_q[2] <= grid_pt(grid_dx_i, base + IW'(3));
      gx1_q[3] <= grid_pt(grid_dx_i, base + IW'(4));
      gy1_q[0] <= grid_pt(grid_dy_i, base);
      gy1_q[1] <= grid_pt(grid_dy_i, base + IW'(1));
      gy1_q[2] <= grid_pt(grid_dy_i, base + IW'(3));
      gy1_q[3] <= grid_pt(grid_dy_i, base + IW'(4));
    end
  end

  // stage 2: corner weights
  logic [WW-1:0]        w2_q [4];
  logic signed [LW-1:0] lx2_q, ly2_q;
  logic signed [OFFSET_BITS-1:0] gx2_q [4];
  logic signed [OFFSET_BITS-1:0] gy2_q [4];

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      w2_q[0] <= WW'(cx0_q) * WW'(cy0_q);
      w2_q[1] <= WW'(cx1_q) * WW'(cy0_q);
      w2_q[2] <= WW'(cx0_q) * WW'(cy1_q);
      w2_q[3] <= WW'(cx1_q) * WW'(cy1_q);
      lx2_q   <= lx1_q;
      ly2_q   <= ly1_q;
      gx2_q   <= gx1_q;
      gy2_q   <= gy1_q;
    end
  end

  // stage 3: weighted offsets
  logic signed [PRW-1:0] px3_q [4];
  logic signed [PRW-1:0] py3_q [4];
  logic signed [LW-1:0]  lx3_q, ly3_q;

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      for (int k = 0; k < 4; k++) begin
        px3_q[k] <= PRW'($signed({1'b0, w2_q[k]})) * PRW'(gx2_q[k]);
        py3_q[k] <= PRW'($signed({1'b0, w2_q[k]})) * PRW'(gy2_q[k]);
      end
      lx3_q <= lx2_q;
      ly3_q <= ly2_q;
    end
  end

  // stage 4: correction sums
  logic signed [DDW-1:0] ddx4_q, ddy4_q;
  logic signed [LW-1:0]  lx4_q, ly4_q;

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      ddx4_q <= DDW'(px3_q[0]) + DDW'(px3_q[1]) + DDW'(px3_q[2]) + DDW'(px3_q[3]);
      ddy4_q <= DDW'(py3_q[0]) + DDW'(py3_q[1]) + DDW'(py3_q[2]) + DDW'(py3_q[3]);
      lx4_q  <= lx3_q;
      ly4_q  <= ly3_q;
    end
  end

  // stage 5: correction to Q(FRAC) toward zero, add to linear term
  logic signed [DDW-1:0] ddxb, ddyb;
  logic signed [DQW-1:0] ddxq, ddyq;
  logic signed [SW-1:0]  sx5_q, sy5_q;

  always_comb begin
    ddxb = ddx4_q + $signed({{(DDW-FRAC_BITS){1'b0}}, {FRAC_BITS{ddx4_q[DDW-1]}}});
    ddyb = ddy4_q + $signed({{(DDW-FRAC_BITS){1'b0}}, {FRAC_BITS{ddy4_q[DDW-1]}}});
    ddxq = $signed(ddxb[DDW-1:FRAC_BITS]);
    ddyq = $signed(ddyb[DDW-1:FRAC_BITS]);
  end

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      sx5_q <= SW'(lx4_q) + SW'(ddxq);
      sy5_q <= SW'(ly4_q) + SW'(ddyq);
    end
  end

  // stage 6: whole pixels toward zero
  logic signed [SW-1:0] sxb, syb;
  logic signed [OW-1:0] px6_q, py6_q;

  always_comb begin
    sxb = sx5_q + $signed({{(SW-FRAC_BITS){1'b0}}, {FRAC_BITS{sx5_q[SW-1]}}});
    syb = sy5_q + $signed({{(SW-FRAC_BITS){1'b0}}, {FRAC_BITS{sy5_q[SW-1]}}});
  end

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      px6_q <= OW'($signed(sxb[SW-1:FRAC_BITS]));
      py6_q <= OW'($signed(syb[SW-1:FRAC_BITS]));
    end
  end

  logic signed [OW-1:0] sw_s, sh_s;
  assign sw_s = $signed(OW'(eff_w(screen_i, orient_i)));
  assign sh_s = $signed(OW'(eff_h(screen_i, orient_i)));

  // stage 7: axis swaps
  logic signed [OW-1:0] px7_q, py7_q;

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      px7_q <= orient_i[OR_SWAP_X] ? (sw_s - px6_q) : px6_q;
      py7_q <= orient_i[OR_SWAP_Y] ? (sh_s - py6_q) : py6_q;
    end
  end

  // stage 8: panel rotation
  logic signed [OW-1:0] px8_d, py8_d, px8_q, py8_q;

  always_comb begin
    unique case (panel_e'(orient_i[OR_PANEL +: 2]))
      PANEL_CW: begin
        px8_d = py7_q;
        py8_d = sw_s - px7_q;
      end
      PANEL_CCW: begin
        px8_d = sh_s - py7_q;
        py8_d = px7_q;
      end
      default: begin
        px8_d = px7_q;
        py8_d = py7_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      px8_q <= px8_d;
      py8_q <= py8_d;
    end
  end

  // stage 9: display rotation
  logic signed [OW-1:0] px9_d, py9_d, px9_q, py9_q;

  always_comb begin
    unique case (disp_e'(orient_i[OR_DISP +: 2]))
      DISP_0: begin
        px9_d = px8_q;
        py9_d = py8_q;
      end
      DISP_90: begin
        px9_d = sh_s - py8_q;
        py9_d = px8_q;
      end
      DISP_180: begin
        px9_d = sw_s - px8_q;
        py9_d = sh_s - py8_q;
      end
      default: begin
        px9_d = py8_q;
        py9_d = sw_s - px8_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      px9_q <= px9_d;
      py9_q <= py9_d;
    end
  end

  // stage 10: saturate, or pass the raw readings
  logic signed [OUT_W-1:0] sx_d, sy_d;
  logic                    raw_pass;

  always_comb begin
    if (px9_q > SAT_HI) begin
      sx_d = OUT_W'(SAT_MAX);
    end else if (px9_q < SAT_LO) begin
      sx_d = OUT_W'(SAT_MIN);
    end else begin
      sx_d = px9_q[OUT_W-1:0];
    end
    if (py9_q > SAT_HI) begin
      sy_d = OUT_W'(SAT_MAX);
    end else if (py9_q < SAT_LO) begin
      sy_d = OUT_W'(SAT_MIN);
    end else begin
      sy_d = py9_q[OUT_W-1:0];
    end
    raw_pass = orient_i[OR_BYPASS] || fault_q[SIDE-1];
  end

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      screen_x_o    <= raw_pass ? $signed(OUT_W'(rxs_q[SIDE-1])) : sx_d;
      screen_y_o    <= raw_pass ? $signed(OUT_W'(rys_q[SIDE-1])) : sy_d;
      range_fault_o <= fault_q[SIDE-1] && !orient_i[OR_BYPASS];
    end
  end

endmodule

`default_nettype wire

[sv/touch_grid_calibrate_map.sv]
// ----------------------------------------------------------------------------
// touch_grid_calibrate_map
// Raw touch sample to screen position with 3x3 grid bilinear correction.
// ----------------------------------------------------------------------------
// One sample enters per clock while the pipeline is not stalled, and its
// position leaves through the two-word output buffer. The four pipelined
// dividers retire one quotient bit per stage over RAW_BITS+16+FRAC_BITS
// stages; three front stages, ten correction and orientation stages and
// the output register surround them. The whole pipeline stalls only while
// the two-word output buffer is full. Write the configuration registers
// only with no sample in flight.
`default_nettype none

`include "assert_macros.svh"

module touch_grid_calibrate_map #(
  parameter int RAW_BITS    = tgc_pkg::RAW_BITS_DEF,
  parameter int OFFSET_BITS = tgc_pkg::OFFSET_BITS_DEF,
  parameter int FRAC_BITS   = tgc_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                       clk_i,
  input  wire logic                                       rst_ni,
  input  wire logic                                       cfg_we_i,
  input  wire logic [tgc_pkg::CFG_IDX_W-1:0]              cfg_idx_i,
  input  wire logic [tgc_pkg::GRID_PTS*OFFSET_BITS-1:0]   cfg_data_i,
  tgc_in_if.sink                                          in_if,
  tgc_out_if.source                                       out_if
);
  import tgc_pkg::*;

  localparam int NW  = RAW_BITS + DIM_W + FRAC_BITS;
  localparam int GW  = GRID_PTS * OFFSET_BITS;
  localparam int LAT = 3 + NW + 10;

  // configuration registers
  logic [RAW_BITS-1:0] x_min_q, x_max_q, y_min_q, y_max_q;
  logic [SCREEN_W-1:0] screen_q;
  logic [ORIENT_W-1:0] orient_q;
  logic [GW-1:0]       grid_dx_q, grid_dy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_min_q   <= '0;
      x_max_q   <= '1;
      y_min_q   <= '0;
      y_max_q   <= '1;
      screen_q  <= SCREEN_RST;
      orient_q  <= '0;
      grid_dx_q <= '0;
      grid_dy_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_X_MIN:   x_min_q   <= cfg_data_i[RAW_BITS-1:0];
        CFG_X_MAX:   x_max_q   <= cfg_data_i[RAW_BITS-1:0];
        CFG_Y_MIN:   y_min_q   <= cfg_data_i[RAW_BITS-1:0];
        CFG_Y_MAX:   y_max_q   <= cfg_data_i[RAW_BITS-1:0];
        CFG_SCREEN:  screen_q  <= cfg_data_i[SCREEN_W-1:0];
        CFG_ORIENT:  orient_q  <= cfg_data_i[ORIENT_W-1:0];
        CFG_GRID_DX: grid_dx_q <= cfg_data_i;
        default:     grid_dy_q <= cfg_data_i;
      endcase
    end
  end

  // pipeline advance: hold everything while the skid word is occupied
  logic ce, in_fire, take;
  logic [LAT-1:0] v_q;
  logic out_v_q, skid_v_q;

  assign ce          = !skid_v_q;
  assign in_if.ready = ce;
  assign in_fire     = in_if.valid && ce;
  assign take        = out_v_q && out_if.ready;

  // front end
  tgc_flags_t          fl_f;
  logic [RAW_BITS-1:0] rx_f, ry_f, mx_f, my_f, hx_f, hy_f;
  logic [NW-1:0]       lnx_f, lny_f, fnx_f, fny_f;

  tgc_front #(
    .RAW_BITS  (RAW_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .ce_i        (ce),
    .raw_x_i     (in_if.raw_x),
    .raw_y_i     (in_if.raw_y),
    .x_min_i     (x_min_q),
    .x_max_i     (x_max_q),
    .y_min_i     (y_min_q),
    .y_max_i     (y_max_q),
    .screen_i    (screen_q),
    .orient_i    (orient_q),
    .flags_o     (fl_f),
    .rx_o        (rx_f),
    .ry_o        (ry_f),
    .lin_x_num_o (lnx_f),
    .lin_y_num_o (lny_f),
    .frc_x_num_o (fnx_f),
    .frc_y_num_o (fny_f),
    .mx_o        (mx_f),
    .my_o        (my_f),
    .hx_o        (hx_f),
    .hy_o        (hy_f)
  );

  // dividers
  logic [NW-1:0] qlx, qly, qfx, qfy;

  tgc_div #(.NW(NW), .DW(RAW_BITS)) u_div_lx (
    .clk_i (clk_i), .ce_i (ce), .dividend_i (lnx_f), .divisor_i (mx_f), .quotient_o (qlx)
  );
  tgc_div #(.NW(NW), .DW(RAW_BITS)) u_div_ly (
    .clk_i (clk_i), .ce_i (ce), .dividend_i (lny_f), .divisor_i (my_f), .quotient_o (qly)
  );
  tgc_div #(.NW(NW), .DW(RAW_BITS)) u_div_fx (
    .clk_i (clk_i), .ce_i (ce), .dividend_i (fnx_f), .divisor_i (hx_f), .quotient_o (qfx)
  );
  tgc_div #(.NW(NW), .DW(RAW_BITS)) u_div_fy (
    .clk_i (clk_i), .ce_i (ce), .dividend_i (fny_f), .divisor_i (hy_f), .quotient_o (qfy)
  );

  // side band alongside the dividers
  tgc_flags_t          fl_dq [NW];
  logic [RAW_BITS-1:0] rx_dq [NW];
  logic [RAW_BITS-1:0] ry_dq [NW];

  always_ff @(posedge clk_i) begin
    if (ce) begin
      fl_dq[0] <= fl_f;
      rx_dq[0] <= rx_f;
      ry_dq[0] <= ry_f;
      for (int k = 1; k < NW; k++) begin
        fl_dq[k] <= fl_dq[k-1];
        rx_dq[k] <= rx_dq[k-1];
        ry_dq[k] <= ry_dq[k-1];
      end
    end
  end

  // back end
  logic signed [OUT_W-1:0] sx_b, sy_b;
  logic                    rf_b;

  tgc_back #(
    .RAW_BITS    (RAW_BITS),
    .OFFSET_BITS (OFFSET_BITS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .ce_i          (ce),
    .lin_x_i       (qlx),
    .lin_y_i       (qly),
    .frc_x_i       (qfx),
    .frc_y_i       (qfy),
    .flags_i       (fl_dq[NW-1]),
    .rx_i          (rx_dq[NW-1]),
    .ry_i          (ry_dq[NW-1]),
    .screen_i      (screen_q),
    .orient_i      (orient_q),
    .grid_dx_i     (grid_dx_q),
    .grid_dy_i     (grid_dy_q),
    .screen_x_o    (sx_b),
    .screen_y_o    (sy_b),
    .range_fault_o (rf_b)
  );

  // valid bits and output buffering
  logic new_v;
  assign new_v = v_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q      <= '0;
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      if (ce) begin
        v_q <= {v_q[LAT-2:0], in_fire};
      end
      if (skid_v_q) begin
        if (take) begin
          skid_v_q <= 1'b0;
        end
      end else if (!out_v_q || take) begin
        out_v_q <= new_v;
      end else if (new_v) begin
        skid_v_q <= 1'b1;
      end
    end
  end

  logic signed [OUT_W-1:0] out_x_q, out_y_q, skid_x_q, skid_y_q;
  logic                    out_f_q, skid_f_q;

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (take) begin
        out_x_q <= skid_x_q;
        out_y_q <= skid_y_q;
        out_f_q <= skid_f_q;
      end
    end else if (!out_v_q || take) begin
      out_x_q <= sx_b;
      out_y_q <= sy_b;
      out_f_q <= rf_b;
    end else begin
      skid_x_q <= sx_b;
      skid_y_q <= sy_b;
      skid_f_q <= rf_b;
    end
  end

  assign out_if.valid       = out_v_q;
  assign out_if.screen_x    = out_x_q;
  assign out_if.screen_y    = out_y_q;
  assign out_if.range_fault = out_f_q;

  `TGC_ASSERT_IMP(a_skid_needs_out, skid_v_q, out_v_q)
  `TGC_ASSERT_NXT(a_stall_holds_pipe, !ce, $stable(v_q))
  `TGC_ASSERT_IMP(a_skid_fill_on_block, $rose(skid_v_q), $past(out_v_q && !out_if.ready))

endmodule

`default_nettype wire

[verif/tb_touch_grid_calibrate_map.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_touch_grid_calibrate_map
// Self-checking bench for the raw touch to screen position mapper: a short
// table of directed samples and register writes, then random phases with
// random settings, idle and stall patterns, each word checked against its
// table value or an internal model of grid correction and orientation.
// ----------------------------------------------------------------------------
module tb_touch_grid_calibrate_map;
  import tgc_pkg::*;

  localparam int RAW_W = RAW_BITS_DEF;
  localparam int OFF_W = OFFSET_BITS_DEF;
  localparam int DATA_W = GRID_PTS * OFF_W;
  localparam longint ONE_Q = longint'(1) << FRAC_BITS_DEF;

  typedef struct {
    logic signed [OUT_W-1:0] sx;
    logic signed [OUT_W-1:0] sy;
    logic                    flt;
  } position_t;

  typedef enum logic {ROW_REG, ROW_SAMPLE} row_kind_e;

  typedef struct {
    row_kind_e               kind;
    cfg_idx_e                idx;
    logic [DATA_W-1:0]       data;
    logic [RAW_W-1:0]        x;
    logic [RAW_W-1:0]        y;
    bit                      typed;
    position_t               want;
  } stim_row_t;

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [DATA_W-1:0] cfg_data_i;

  tgc_in_if  in_ch ();
  tgc_out_if out_ch ();

  touch_grid_calibrate_map DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_if      (in_ch),
    .out_if     (out_ch)
  );

  // register copies
  logic [RAW_W-1:0] x_min, x_max, y_min, y_max;
  logic [SCREEN_W-1:0] screen;
  logic [ORIENT_W-1:0] orient;
  logic [DATA_W-1:0] grid_x, grid_y;

  position_t pending_pos[$];
  stim_row_t table_rows[$];
  int mismatches = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic longint grid_offset(logic [DATA_W-1:0] g, int i);
    logic signed [OFF_W-1:0] v;
    v = g[OFF_W*i +: OFF_W];
    return longint'(v);
  endfunction

  function automatic longint quad_frac(longint n, longint h);
    if (n < 0) n = 0;
    if (n > h) n = h;
    return (n * ONE_Q) / h;
  endfunction

  function automatic longint clip17(longint v);
    if (v < SAT_MIN) return SAT_MIN;
    if (v > SAT_MAX) return SAT_MAX;
    return v;
  endfunction

  function automatic position_t map_position(logic [RAW_W-1:0] rx, logic [RAW_W-1:0] ry);
    position_t r;
    longint xc, yc, mx, my, ox, oy, pw, ph, sw, sh, hx, hy;
    longint cx0, cx1, cy0, cy1, w00, w01, w10, w11, ddx, ddy, px, py, t;
    int col, row, b;
    panel_e pnl;
    disp_e dsp;
    xc = longint'(rx) - longint'(x_min);
    yc = longint'(ry) - longint'(y_min);
    mx = longint'(x_max) - longint'(x_min);
    my = longint'(y_max) - longint'(y_min);
    ox = rx;
    oy = ry;
    r.flt = 1'b0;
    pnl = panel_e'(orient[OR_PANEL +: 2]);
    dsp = disp_e'(orient[OR_DISP +: 2]);
    if (orient[OR_BYPASS]) begin
    end else if (mx < 2 || my < 2) begin
      r.flt = 1'b1;
    end else begin
      pw = screen[15:0];
      ph = screen[31:16];
      sw = pw;
      sh = ph;
      hx = mx / 2;
      hy = my / 2;
      col = (xc < hx) ? 0 : 1;
      row = (yc > hy) ? 0 : 1;
      cx1 = quad_frac(col ? xc - hx : xc, hx);
      cy0 = quad_frac(row ? yc : yc - hy, hy);
      cx0 = ONE_Q - cx1;
      cy1 = ONE_Q - cy0;
      b = 3 * row + col;
      w00 = cx0 * cy0;
      w01 = cx1 * cy0;
      w10 = cx0 * cy1;
      w11 = cx1 * cy1;
      if (pnl == PANEL_CW || pnl == PANEL_CCW) begin
        sw = ph;
        sh = pw;
      end
      ddx = w00 * grid_offset(grid_x, b) + w01 * grid_offset(grid_x, b + 1)
          + w10 * grid_offset(grid_x, b + 3) + w11 * grid_offset(grid_x, b + 4);
      ddy = w00 * grid_offset(grid_y, b) + w01 * grid_offset(grid_y, b + 1)
          + w10 * grid_offset(grid_y, b + 3) + w11 * grid_offset(grid_y, b + 4);
      px = ((xc * sw * ONE_Q) / mx + ddx / ONE_Q) / ONE_Q;
      py = ((yc * sh * ONE_Q) / my + ddy / ONE_Q) / ONE_Q;
      if (orient[OR_SWAP_Y]) py = sh - py;
      if (orient[OR_SWAP_X]) px = sw - px;
      if (pnl == PANEL_CW) begin
        t = px; px = py; py = sw - t;
      end else if (pnl == PANEL_CCW) begin
        t = px; px = sh - py; py = t;
      end
      case (dsp)
        DISP_0: begin ox = px; oy = py; end
        DISP_90: begin ox = sh - py; oy = px; end
        DISP_180: begin ox = sw - px; oy = sh - py; end
        default: begin ox = py; oy = sw - px; end
      endcase
      ox = clip17(ox);
      oy = clip17(oy);
    end
    r.sx = ox[OUT_W-1:0];
    r.sy = oy[OUT_W-1:0];
    return r;
  endfunction

  // Drain the pipeline, then write one register.
  task automatic write_reg(cfg_idx_e idx, logic [DATA_W-1:0] val);
    in_ch.valid <= 1'b0;
    while (pending_pos.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_X_MIN: x_min = val[RAW_W-1:0];
      CFG_X_MAX: x_max = val[RAW_W-1:0];
      CFG_Y_MIN: y_min = val[RAW_W-1:0];
      CFG_Y_MAX: y_max = val[RAW_W-1:0];
      CFG_SCREEN: screen = val[SCREEN_W-1:0];
      CFG_ORIENT: orient = val[ORIENT_W-1:0];
      CFG_GRID_DX: grid_x = val;
      default: grid_y = val;
    endcase
  endtask

  // Offer one sample; valid stays high for a back-to-back follower.
  task automatic send_sample(logic [RAW_W-1:0] x, logic [RAW_W-1:0] y, bit typed,
                             position_t want);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.raw_x <= x;
    in_ch.raw_y <= y;
    do @(posedge clk_i); while (!in_ch.ready);
    pending_pos.push_back(typed ? want : map_position(x, y));
  endtask

  function automatic void add_reg(cfg_idx_e idx, logic [DATA_W-1:0] val);
    stim_row_t r;
    r.kind = ROW_REG;
    r.idx = idx;
    r.data = val;
    r.typed = 0;
    table_rows.push_back(r);
  endfunction

  function automatic void add_sample(logic [RAW_W-1:0] x, logic [RAW_W-1:0] y, bit typed,
                                     int ex, int ey, logic ef);
    stim_row_t r;
    r.kind = ROW_SAMPLE;
    r.idx = CFG_X_MIN;
    r.x = x;
    r.y = y;
    r.typed = typed;
    r.want.sx = ex[OUT_W-1:0];
    r.want.sy = ey[OUT_W-1:0];
    r.want.flt = ef;
    table_rows.push_back(r);
  endfunction

  function automatic logic [RAW_W-1:0] pick_raw(logic [RAW_W-1:0] lo, logic [RAW_W-1:0] hi);
    if ($urandom_range(9) == 0 || lo >= hi) return $urandom_range(16383);
    return $urandom_range(hi, lo);
  endfunction

  // receiver
  initial begin
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_cycles > 0) begin
        out_ch.ready <= 1'b0;
        hold_cycles = hold_cycles - 1;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // checker
  always @(posedge clk_i) begin
    position_t w;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_pos.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: x=%0d y=%0d fault=%0b",
                                       out_ch.screen_x, out_ch.screen_y, out_ch.range_fault);
      end else begin
        w = pending_pos.pop_front();
        if (out_ch.screen_x !== w.sx || out_ch.screen_y !== w.sy
            || out_ch.range_fault !== w.flt) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected x=%0d y=%0d fault=%0b, got x=%0d y=%0d fault=%0b",
                     w.sx, w.sy, w.flt, out_ch.screen_x, out_ch.screen_y,
                     out_ch.range_fault);
        end
      end
    end
  end

  initial begin
    logic [RAW_W-1:0] a, b;
    logic [DATA_W-1:0] v;
    int n;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_X_MIN;
    cfg_data_i = '0;
    in_ch.valid = 1'b0;
    in_ch.raw_x = '0;
    in_ch.raw_y = '0;
    x_min = 0; x_max = 16383; y_min = 0; y_max = 16383;
    screen = SCREEN_RST; orient = '0; grid_x = '0; grid_y = '0;

    // defaults: 800 x 600, no correction
    add_sample(0, 0, 1, 0, 0, 0);
    add_sample(16383, 16383, 1, 800, 600, 0);
    add_sample(8191, 8192, 0, 0, 0, 0);
    add_sample(8192, 8191, 0, 0, 0, 0);
    add_reg(CFG_ORIENT, 1 << OR_BYPASS);
    add_sample(16383, 0, 1, 16383, 0, 0);
    add_sample(0, 16383, 1, 0, 16383, 0);
    add_reg(CFG_ORIENT, 0);
    add_reg(CFG_X_MAX, 1);
    add_sample(5, 9, 1, 5, 9, 1);
    add_reg(CFG_X_MAX, 16383);
    add_reg(CFG_Y_MIN, 16383);
    add_sample(12345, 678, 1, 12345, 678, 1);
    add_reg(CFG_Y_MIN, 100);
    add_reg(CFG_Y_MAX, 10000);
    add_reg(CFG_SCREEN, 32'hFFFF_FFFF);
    add_reg(CFG_GRID_DX, {GRID_PTS{7'h3f}});
    add_reg(CFG_GRID_DY, {GRID_PTS{7'h40}});
    add_sample(16383, 0, 0, 0, 0, 0);
    add_sample(0, 16383, 0, 0, 0, 0);
    add_sample(8191, 5050, 0, 0, 0, 0);
    add_reg(CFG_ORIENT, (1 << OR_SWAP_X) | (1 << OR_SWAP_Y) | (PANEL_CW << OR_PANEL)
                        | (DISP_90 << OR_DISP));
    add_sample(3000, 9000, 0, 0, 0, 0);
    add_reg(CFG_ORIENT, (PANEL_CCW << OR_PANEL) | (DISP_180 << OR_DISP));
    add_sample(12000, 2000, 0, 0, 0, 0);
    add_reg(CFG_ORIENT, (PANEL_RSVD << OR_PANEL) | (DISP_270 << OR_DISP));
    add_sample(7000, 7000, 0, 0, 0, 0);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (table_rows[i]) begin
      if (table_rows[i].kind == ROW_REG) write_reg(table_rows[i].idx, table_rows[i].data);
      else send_sample(table_rows[i].x, table_rows[i].y, table_rows[i].typed,
                       table_rows[i].want);
    end

    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 84; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 84; end
        default: begin send_idle_pct = 14; recv_stall_pct = 14; end
      endcase
      if (p == 0) begin
        a = 0; b = 16383;
      end else begin
        a = $urandom_range(16383);
        b = ($urandom_range(7) == 0) ? a + $urandom_range(1) : $urandom_range(16383);
      end
      write_reg(CFG_X_MIN, a);
      write_reg(CFG_X_MAX, b);
      if (p == 1) begin
        a = 0; b = 16383;
      end else begin
        a = $urandom_range(16383);
        b = ($urandom_range(7) == 0) ? a - $urandom_range(1) : $urandom_range(16383);
      end
      write_reg(CFG_Y_MIN, a);
      write_reg(CFG_Y_MAX, b);
      v = {$urandom, $urandom};
      write_reg(CFG_SCREEN, (p == 2) ? 32'hFFFF_FFFF : (p == 3) ? 32'h0 : v[31:0]);
      v = $urandom_range(127);
      if ($urandom_range(7) != 0) v[OR_BYPASS] = 1'b0;
      write_reg(CFG_ORIENT, v);
      v = {$urandom, $urandom};
      write_reg(CFG_GRID_DX, (p == 4) ? {GRID_PTS{7'h40}} : v);
      v = {$urandom, $urandom};
      write_reg(CFG_GRID_DY, (p == 4) ? {GRID_PTS{7'h3f}} : v);
      // hold off the receiver so the buffer fills and input stalls
      if (p == 0) hold_cycles = 400;
      n = 0;
      while (n < 62) begin
        send_sample(pick_raw(x_min, x_max), pick_raw(y_min, y_max), 0, '{0, 0, 0});
        n++;
      end
    end

    in_ch.valid <= 1'b0;
    n = 0;
    while (pending_pos.size() != 0 && n < 200000) begin
      @(posedge clk_i);
      n++;
    end
    repeat (80) @(posedge clk_i);
    if (mismatches == 0 && pending_pos.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
